[sv/cwips_pkg.sv]
// shared types and constants for the coil write and input poll scheduler
package cwips_pkg;

    localparam int INPUT_COUNT = 6;

    localparam int TIMER_W = 11;
    localparam int ERR_W   = 8;
    localparam int IVL_W   = 10;
    localparam int ADDR_W  = 16;
    localparam int BITS_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [BITS_W-1:0] SENSOR_MASK = (INPUT_COUNT >= BITS_W) ?
        {BITS_W{1'b1}} : BITS_W'((1 << INPUT_COUNT) - 1);

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
    localparam logic [ERR_W-1:0]   ERR_MAX   = {ERR_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_FAST_INTERVAL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_INTERVAL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COIL_BASE_ADDRESS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_BASE_ADDRESS = 3'd4;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_MOTOR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef struct packed {
        logic              motor_target;
        logic              reset_request;
        logic              response_valid;
        logic              response_ok;
        logic [BITS_W-1:0] response_bits;
    } in_item_t;

    typedef struct packed {
        logic              request_valid;
        logic              request_is_write;
        logic [ADDR_W-1:0] request_address;
        logic              coil_value;
        logic              comms_ok;
        logic              motor_on;
        logic [BITS_W-1:0] sensor_bits;
    } out_item_t;

    typedef struct packed {
        logic [IVL_W-1:0]  fast_interval;
        logic [IVL_W-1:0]  slow_interval;
        logic [ERR_W-1:0]  error_limit;
        logic [ADDR_W-1:0] coil_base_address;
        logic [ADDR_W-1:0] input_base_address;
    } cfg_t;

    typedef struct packed {
        logic               last_sent_motor;
        logic               reset_pending;
        logic [TIMER_W-1:0] poll_timer;
        logic [ERR_W-1:0]   error_count;
        logic               force_read;
        logic               link_healthy;
        logic               motor_confirmed;
        logic [BITS_W-1:0]  sensor_store;
        kind_t              outstanding_kind;
        logic               outstanding_value;
        logic               outstanding_had_pending;
    } sched_state_t;

    localparam sched_state_t STATE_RESET = '{
        last_sent_motor:         1'b1,
        reset_pending:           1'b0,
        poll_timer:              '0,
        error_count:             '0,
        force_read:              1'b0,
        link_healthy:            1'b0,
        motor_confirmed:         1'b0,
        sensor_store:            '0,
        outstanding_kind:        KIND_NONE,
        outstanding_value:       1'b0,
        outstanding_had_pending: 1'b0
    };

endpackage

[sv/coil_write_and_input_poll_scheduler.sv]
// top level of the field-bus master coil write and input poll scheduler
//
// one request on s_ per millisecond tick carries the motor command level, the
// alarm-reset pulse and the response to the outstanding bus transaction, if any
// each accepted request yields exactly one result on m_: whether a bus
// transaction is issued, its kind, address and coil value, plus the link health,
// the confirmed motor state and the last read discrete inputs
// the input request is captured in an input register, the scheduler state is
// updated as it moves into the result register, which drives m_
// throughput is one request per cycle while the receiver keeps m_ready high,
// set by the single state update per cycle
// s_ready stays high while the result register is empty or being drained; if the
// receiver stalls, one more request is held in the input register and then
// s_ready drops until m_ready returns
// configuration is a plain write port, used only while the block is idle
// reset (aresetn low, synchronous) empties both registers and returns the
// configuration and scheduler state to their defaults
module coil_write_and_input_poll_scheduler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  cwips_pkg::in_item_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output cwips_pkg::out_item_t              m_data,
    input  logic                              cfg_we,
    input  logic [cwips_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cwips_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import cwips_pkg::*;

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    logic      in_valid_next;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t result;
    logic      advance;

    cwips_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cwips_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[sv/cwips_cfg.sv]
// configuration register bank
module cwips_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [cwips_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cwips_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output cwips_pkg::cfg_t                   cfg
);
    import cwips_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_FAST_INTERVAL:      cfg_next.fast_interval      = cfg_wdata[IVL_W-1:0];
                REG_SLOW_INTERVAL:      cfg_next.slow_interval      = cfg_wdata[IVL_W-1:0];
                REG_ERROR_LIMIT:        cfg_next.error_limit        = cfg_wdata[ERR_W-1:0];
                REG_COIL_BASE_ADDRESS:  cfg_next.coil_base_address  = cfg_wdata[ADDR_W-1:0];
                REG_INPUT_BASE_ADDRESS: cfg_next.input_base_address = cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_interval      <= IVL_W'(5);
            cfg_reg.slow_interval      <= IVL_W'(100);
            cfg_reg.error_limit        <= ERR_W'(15);
            cfg_reg.coil_base_address  <= '0;
            cfg_reg.input_base_address <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/cwips_core.sv]
// scheduler state and the per-tick update and request decision
module cwips_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  cwips_pkg::in_item_t  item,
    input  cwips_pkg::cfg_t      cfg,
    output cwips_pkg::out_item_t result
);
    import cwips_pkg::*;

    sched_state_t state_reg;
    sched_state_t state_next;

    always_comb begin
        sched_state_t s;
        out_item_t    r;
        kind_t        kind;
        logic [IVL_W-1:0] period;
        logic         pending;

        s    = state_reg;
        r    = '0;
        kind = state_reg.outstanding_kind;

        // close the outstanding transaction
        if (item.response_valid && kind != KIND_NONE) begin
            s.outstanding_kind = KIND_NONE;
            if (item.response_ok) begin
                s.error_count  = '0;
                s.link_healthy = 1'b1;
                if (kind == KIND_MOTOR) begin
                    s.last_sent_motor = state_reg.outstanding_value;
                    s.motor_confirmed = state_reg.outstanding_value;
                end else if (kind == KIND_READ) begin
                    s.sensor_store = item.response_bits & SENSOR_MASK;
                end
            end else begin
                if (s.error_count != ERR_MAX) begin
                    s.error_count = s.error_count + ERR_W'(1);
                end
                if (kind != KIND_READ) begin
                    s.force_read = 1'b1;
                end
                if (s.error_count > cfg.error_limit) begin
                    s.link_healthy = 1'b0;
                end
            end
            if (kind == KIND_READ && state_reg.outstanding_had_pending) begin
                s.force_read = 1'b0;
            end
        end

        if (item.reset_request) begin
            s.reset_pending = 1'b1;
        end
        if (s.poll_timer != TIMER_MAX) begin
            s.poll_timer = s.poll_timer + TIMER_W'(1);
        end

        period  = (s.error_count != '0) ? cfg.slow_interval : cfg.fast_interval;
        pending = (item.motor_target != s.last_sent_motor) || s.reset_pending;

        if (s.poll_timer > {1'b0, period} && s.outstanding_kind == KIND_NONE) begin
            s.poll_timer    = '0;
            r.request_valid = 1'b1;
            if (pending && !s.force_read) begin
                r.request_is_write = 1'b1;
                if (s.reset_pending) begin
                    r.request_address   = cfg.coil_base_address + ADDR_W'(1);
                    r.coil_value        = 1'b1;
                    s.reset_pending     = 1'b0;
                    s.outstanding_kind  = KIND_RESET;
                    s.outstanding_value = 1'b1;
                end else begin
                    r.request_address   = cfg.coil_base_address;
                    r.coil_value        = item.motor_target;
                    s.outstanding_kind  = KIND_MOTOR;
                    s.outstanding_value = item.motor_target;
                end
                s.outstanding_had_pending = 1'b1;
            end else begin
                r.request_address         = cfg.input_base_address;
                s.outstanding_kind        = KIND_READ;
                s.outstanding_value       = 1'b0;
                s.outstanding_had_pending = pending;
            end
        end

        r.comms_ok  = s.link_healthy;
        r.motor_on  = s.motor_confirmed;
        r.sensor_bits = s.sensor_store;

        state_next = s;
        result     = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

endmodule

[tb/sv/poll_sched_scoreboard_pkg.sv]
// scoreboard class and stimulus modes for the coil write and input poll scheduler bench
`timescale 1ns / 1ps

package poll_sched_scoreboard_pkg;

    import cwips_pkg::*;

    typedef enum int {
        LINK_STEADY,
        LINK_FLAKY,
        LINK_STORM,
        LINK_MUTE
    } link_mode_t;

    class poll_sched_scoreboard;
        cfg_t         regs;
        sched_state_t st;
        out_item_t    expected_polls[$];
        int           failures;

        function new();
            regs = '{fast_interval: 10'd5, slow_interval: 10'd100, error_limit: 8'd15,
                     coil_base_address: '0, input_base_address: '0};
            st = STATE_RESET;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FAST_INTERVAL: regs.fast_interval = val[IVL_W-1:0];
                REG_SLOW_INTERVAL: regs.slow_interval = val[IVL_W-1:0];
                REG_ERROR_LIMIT: regs.error_limit = val[ERR_W-1:0];
                REG_COIL_BASE_ADDRESS: regs.coil_base_address = val[ADDR_W-1:0];
                REG_INPUT_BASE_ADDRESS: regs.input_base_address = val[ADDR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [ERR_W-1:0] st_limit();
            return regs.error_limit;
        endfunction

        function void take_answer(logic ok, logic [BITS_W-1:0] bits);
            kind_t k;
            k = st.outstanding_kind;
            st.outstanding_kind = KIND_NONE;
            if (ok) begin
                st.error_count = '0;
                st.link_healthy = 1'b1;
                if (k == KIND_MOTOR) begin
                    st.last_sent_motor = st.outstanding_value;
                    st.motor_confirmed = st.outstanding_value;
                end else if (k == KIND_READ) begin
                    st.sensor_store = bits & SENSOR_MASK;
                end
            end else begin
                if (st.error_count != ERR_MAX)
                    st.error_count = st.error_count + ERR_W'(1);
                if (k != KIND_READ)
                    st.force_read = 1'b1;
                if (st.error_count > st_limit())
                    st.link_healthy = 1'b0;
            end
            if (k == KIND_READ && st.outstanding_had_pending)
                st.force_read = 1'b0;
        endfunction

        function void note_request(in_item_t it);
            out_item_t        want;
            logic [IVL_W-1:0] period;
            logic             pend;
            want = '0;
            if (it.response_valid && st.outstanding_kind != KIND_NONE)
                take_answer(it.response_ok, it.response_bits);
            if (it.reset_request)
                st.reset_pending = 1'b1;
            if (st.poll_timer != TIMER_MAX)
                st.poll_timer = st.poll_timer + TIMER_W'(1);
            period = (st.error_count != '0) ? regs.slow_interval : regs.fast_interval;
            if (st.poll_timer > {1'b0, period} && st.outstanding_kind == KIND_NONE) begin
                st.poll_timer = '0;
                want.request_valid = 1'b1;
                pend = (it.motor_target != st.last_sent_motor) || st.reset_pending;
                if (pend && !st.force_read) begin
                    want.request_is_write = 1'b1;
                    if (st.reset_pending) begin
                        want.request_address = regs.coil_base_address + 16'd1;
                        want.coil_value = 1'b1;
                        st.reset_pending = 1'b0;
                        st.outstanding_kind = KIND_RESET;
                        st.outstanding_value = 1'b1;
                    end else begin
                        want.request_address = regs.coil_base_address;
                        want.coil_value = it.motor_target;
                        st.outstanding_kind = KIND_MOTOR;
                        st.outstanding_value = it.motor_target;
                    end
                    st.outstanding_had_pending = 1'b1;
                end else begin
                    want.request_address = regs.input_base_address;
                    st.outstanding_kind = KIND_READ;
                    st.outstanding_value = 1'b0;
                    st.outstanding_had_pending = pend;
                end
            end
            want.comms_ok = st.link_healthy;
            want.motor_on = st.motor_confirmed;
            want.sensor_bits = st.sensor_store;
            expected_polls.push_back(want);
        endfunction

        function void check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_polls.size() == 0) begin
                $error("result 0x%0h arrived with no request outstanding", got);
                failures++;
                return;
            end
            want = expected_polls.pop_front();
            check_field("request_valid", ADDR_W'(want.request_valid),
                        ADDR_W'(got.request_valid));
            check_field("request_is_write", ADDR_W'(want.request_is_write),
                        ADDR_W'(got.request_is_write));
            check_field("request_address", want.request_address, got.request_address);
            check_field("coil_value", ADDR_W'(want.coil_value), ADDR_W'(got.coil_value));
            check_field("comms_ok", ADDR_W'(want.comms_ok), ADDR_W'(got.comms_ok));
            check_field("motor_on", ADDR_W'(want.motor_on), ADDR_W'(got.motor_on));
            check_field("sensor_bits", ADDR_W'(want.sensor_bits), ADDR_W'(got.sensor_bits));
        endfunction

        function int pending();
            return expected_polls.size();
        endfunction
    endclass

endpackage

[tb/sv/tb_coil_write_and_input_poll_scheduler.sv]
// top-level bench driving the poll scheduler and checking every result
`timescale 1ns / 1ps

module tb_coil_write_and_input_poll_scheduler;

    import cwips_pkg::*;
    import poll_sched_scoreboard_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    poll_sched_scoreboard sb;
    logic motor_level = 1'b0;
    logic storm_ok_done = 1'b0;
    logic hold_long = 1'b0;

    always #5 aclk = ~aclk;

    coil_write_and_input_poll_scheduler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    initial begin
        int r;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_long) begin
                m_ready <= 1'b0;
                repeat (80) @(negedge aclk);
                hold_long = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 40)) @(negedge aclk);
                end else if (r < 90) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(negedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(10, 25)) @(negedge aclk);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_item_t tick(bit t, bit rq, bit v, bit ok, logic [BITS_W-1:0] b);
        in_item_t it;
        it = '{t, rq, v, ok, b};
        return it;
    endfunction

    function automatic in_item_t make_tick(link_mode_t mode, int left);
        in_item_t it;
        logic     busy;
        busy = (sb.st.outstanding_kind != KIND_NONE);
        if ($urandom_range(0, 11) == 0)
            motor_level = ~motor_level;
        it.motor_target = motor_level;
        it.reset_request = ($urandom_range(0, 15) == 0);
        it.response_bits = BITS_W'($urandom);
        it.response_ok = ($urandom_range(0, 9) != 0);
        it.response_valid = busy ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 19) == 0);
        case (mode)
            LINK_FLAKY: begin
                it.response_ok = ($urandom_range(0, 1) == 1);
                it.response_valid = busy ? ($urandom_range(0, 1) == 1) :
                                           ($urandom_range(0, 9) == 0);
            end
            LINK_STORM: begin
                it.response_valid = busy;
                it.response_ok = !storm_ok_done;
                if (busy)
                    storm_ok_done = 1'b1;
            end
            LINK_MUTE: begin
                if (left > 40 && busy)
                    it.response_valid = 1'b0;
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic cfg_t rand_settings();
        cfg_t c;
        c.fast_interval = IVL_W'($urandom_range(1, 6));
        c.slow_interval = IVL_W'($urandom_range(1, 6));
        c.error_limit = ERR_W'($urandom_range(0, 20));
        c.coil_base_address = ADDR_W'($urandom);
        c.input_base_address = ADDR_W'($urandom);
        return c;
    endfunction

    task automatic send_request(input in_item_t it, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain(input int extra);
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic apply_settings(input cfg_t c);
        write_cfg(REG_FAST_INTERVAL, CFG_DATA_W'(c.fast_interval));
        write_cfg(REG_SLOW_INTERVAL, CFG_DATA_W'(c.slow_interval));
        write_cfg(REG_ERROR_LIMIT, CFG_DATA_W'(c.error_limit));
        write_cfg(REG_COIL_BASE_ADDRESS, c.coil_base_address);
        write_cfg(REG_INPUT_BASE_ADDRESS, c.input_base_address);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input cfg_t c, input link_mode_t mode, input int len,
                             input bit squeeze);
        in_item_t it;
        int       gap;
        drain(4);
        apply_settings(c);
        storm_ok_done = 1'b0;
        for (int i = 0; i < len; i++) begin
            if (squeeze && i == len / 3)
                hold_long = 1'b1;
            if (squeeze && i == 2 * len / 3)
                drain(0);
            it = make_tick(mode, len - i);
            gap = hold_long ? 0 : pick_gap();
            send_request(it, gap);
        end
    endtask

    initial begin
        cfg_t c;
        sb = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // alarm reset, failed writes forcing reads, stray response, wide bits
        apply_settings('{10'd1, 10'd1, 8'd1, 16'h1234, 16'hABCD});
        send_request(tick(0, 1, 0, 0, 6'h00), pick_gap());
        send_request(tick(0, 0, 0, 0, 6'h00), pick_gap());
        send_request(tick(0, 0, 1, 0, 6'h3F), pick_gap());
        send_request(tick(0, 0, 0, 0, 6'h00), pick_gap());
        send_request(tick(0, 0, 1, 1, 6'h3F), pick_gap());
        send_request(tick(0, 0, 0, 0, 6'h00), pick_gap());
        send_request(tick(0, 0, 1, 0, 6'h00), pick_gap());
        send_request(tick(0, 0, 0, 0, 6'h00), pick_gap());
        send_request(tick(0, 0, 1, 0, 6'h15), pick_gap());
        send_request(tick(0, 0, 0, 0, 6'h00), pick_gap());
        send_request(tick(0, 0, 1, 1, 6'h00), pick_gap());
        send_request(tick(1, 1, 1, 1, 6'h2A), pick_gap());
        send_request(tick(1, 0, 1, 1, 6'h00), pick_gap());
        send_request(tick(1, 0, 0, 0, 6'h00), pick_gap());
        send_request(tick(1, 0, 1, 1, 6'h00), pick_gap());
        send_request(tick(1, 0, 0, 0, 6'h00), pick_gap());
        send_request(tick(1, 0, 1, 1, 6'h00), pick_gap());
        send_request(tick(0, 0, 0, 0, 6'h3F), pick_gap());
        send_request(tick(0, 1, 1, 1, 6'h3F), pick_gap());
        send_request(tick(0, 0, 0, 0, 6'h00), pick_gap());
        send_request(tick(0, 0, 1, 1, 6'h00), pick_gap());
        motor_level = 1'b0;

        run_phase(rand_settings(), LINK_STEADY, 220, 1'b1);
        run_phase('{10'd1, 10'd1, 8'd0, 16'hFFFF, 16'h0000}, LINK_FLAKY, 200, 1'b0);
        // zero period and a limit of 255 under a long failure run
        run_phase('{10'd0, 10'd1, 8'd255, 16'h0000, 16'hFFFF}, LINK_STORM, 600, 1'b0);
        c = rand_settings();
        c.fast_interval = 10'd1023;
        c.slow_interval = 10'd1023;
        c.error_limit = 8'd254;
        run_phase(c, LINK_STEADY, 100, 1'b0);
        // transaction left open for a long stretch
        c = rand_settings();
        c.fast_interval = 10'd2;
        c.slow_interval = 10'd3;
        c.error_limit = 8'd254;
        run_phase(c, LINK_MUTE, 300, 1'b0);
        c = rand_settings();
        c.error_limit = ERR_W'($urandom_range(0, 254));
        run_phase(c, LINK_FLAKY, 230, 1'b0);
        run_phase(rand_settings(), LINK_STEADY, 230, 1'b0);

        drain(0);
        repeat (6) @(posedge aclk);
        if (sb.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
